### src/nnr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_pkg
// Shared types, widths and codes for the nearest neighbour recommender.
// ----------------------------------------------------------------------------
package nnr_pkg;

    // Store geometry
    localparam int MAX_USERS  = 64;
    localparam int MAX_BOOKS  = 128;
    localparam int UIDX_W     = $clog2(MAX_USERS);
    localparam int BIDX_W     = $clog2(MAX_BOOKS);
    localparam int ADDR_W     = UIDX_W + BIDX_W;
    localparam int RATE_W     = 4;
    localparam int DEPTH      = MAX_USERS * MAX_BOOKS;

    // Counter and register widths (counters can hold the full count)
    localparam int NU_W       = UIDX_W + 1;
    localparam int NB_W       = BIDX_W + 1;
    localparam int RESULT_CAP = 16;
    localparam int CAP_W      = 5;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;

    // Squared difference is at most 10*10, the sum at most MAX_BOOKS*100
    localparam int SQ_W       = 7;
    localparam int SSD_W      = $clog2(MAX_BOOKS * 100 + 1);

    // Result kinds
    localparam logic [1:0] KIND_OK     = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_REC    = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_USERS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BOOKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIKE_THRSH = 2'd3;

    // Command transfer
    typedef struct packed {
        logic                     action;
        logic [UIDX_W-1:0]        user_index;
        logic [BIDX_W-1:0]        book_index;
        logic signed [RATE_W-1:0] rating_value;
    } cmd_t;

    // Result transfer
    typedef struct packed {
        logic [1:0]        kind;
        logic [BIDX_W-1:0] rec_book;
        logic [UIDX_W-1:0] neighbour;
        logic              last;
    } res_t;

    // Effective (saturated) settings seen by the query engine
    typedef struct packed {
        logic [NU_W-1:0]          nu;
        logic [NB_W-1:0]          nbk;
        logic [CAP_W-1:0]         cap;
        logic signed [RATE_W-1:0] thr;
    } qcfg_t;

    // Query launch
    typedef struct packed {
        logic              go;
        logic [UIDX_W-1:0] user;
    } qreq_t;

endpackage

### src/nnr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module nnr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### src/nnr_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_query
// Query engine: scans every other user for the smallest sum of squared rating
// differences, then walks the books to emit recommendations.
// ----------------------------------------------------------------------------
module nnr_query (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nnr_pkg::qreq_t                req,
    input  nnr_pkg::qcfg_t                cfg,
    output logic [nnr_pkg::ADDR_W-1:0]    raddr_q,
    input  logic [nnr_pkg::RATE_W-1:0]    rdata_q,
    output logic [nnr_pkg::ADDR_W-1:0]    raddr_n,
    input  logic [nnr_pkg::RATE_W-1:0]    rdata_n,
    output logic                          busy,
    output nnr_pkg::res_t                 res,
    output logic                          res_valid
);
    import nnr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_PICK = 4'b0100,
        ST_EMIT = 4'b1000
    } qstate_t;

    qstate_t           state_reg, state_next;
    logic [UIDX_W-1:0] user_reg, user_next;
    logic [NU_W-1:0]   i_reg, i_next;
    logic [NB_W-1:0]   b_reg, b_next;
    logic [SSD_W-1:0]  acc_reg, acc_next;
    logic [SSD_W-1:0]  best_reg, best_next;
    logic              found_reg, found_next;
    logic [UIDX_W-1:0] nb_reg, nb_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    logic              rd_use_reg, rd_use_next;
    logic [UIDX_W-1:0] rd_user_reg, rd_user_next;
    logic [BIDX_W-1:0] rd_book_reg, rd_book_next;
    logic [CAP_W-1:0]  count_reg, count_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BIDX_W-1:0] pend_book_reg, pend_book_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic signed [RATE_W-1:0] q_rating, n_rating;
    logic signed [RATE_W:0]   diff;
    logic signed [9:0]        prod;
    logic [SQ_W-1:0]          sq;
    logic [SSD_W-1:0]         total;
    logic [NB_W-1:0]          b_last;
    logic                     emit_done;
    logic                     liked;

    // Read addresses: querier row and candidate/neighbour row
    assign raddr_q = {user_reg, b_reg[BIDX_W-1:0]};
    assign raddr_n = {(state_reg == ST_EMIT) ? nb_reg : i_reg[UIDX_W-1:0],
                      b_reg[BIDX_W-1:0]};

    // Squared difference of the returned pair
    assign q_rating = rdata_q;
    assign n_rating = rdata_n;
    assign diff     = {q_rating[RATE_W-1], q_rating} - {n_rating[RATE_W-1], n_rating};
    assign prod     = diff * diff;
    assign sq       = rd_use_reg ? prod[SQ_W-1:0] : '0;
    assign total    = acc_reg + SSD_W'(sq);

    // Per-user book sweep covers at least one slot so empty rows still compare
    assign b_last    = (cfg.nbk == '0) ? '0 : cfg.nbk - NB_W'(1);
    assign emit_done = (b_reg >= cfg.nbk) || (count_reg >= cfg.cap);
    assign liked     = (q_rating == '0) && (n_rating >= cfg.thr);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        user_next       = user_reg;
        i_next          = i_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        nb_next         = nb_reg;
        rd_valid_next   = 1'b0;
        rd_last_next    = rd_last_reg;
        rd_use_next     = rd_use_reg;
        rd_user_next    = rd_user_reg;
        rd_book_next    = rd_book_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_book_next  = pend_book_reg;
        res_next        = res_reg;
        res_valid_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.go)
                begin
                    user_next  = req.user;
                    i_next     = '0;
                    b_next     = '0;
                    acc_next   = '0;
                    found_next = 1'b0;
                    nb_next    = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Returned data: accumulate, compare at end of row
                if (rd_valid_reg)
                begin
                    if (rd_last_reg)
                    begin
                        acc_next = '0;
                        if (!found_reg || (total <= best_reg))
                        begin
                            best_next  = total;
                            nb_next    = rd_user_reg;
                            found_next = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_next = total;
                    end
                end
                // Issue next read
                if (i_reg >= cfg.nu)
                begin
                    state_next = ST_PICK;
                end
                else if (i_reg[UIDX_W-1:0] == user_reg)
                begin
                    i_next = i_reg + NU_W'(1);
                end
                else
                begin
                    rd_valid_next = 1'b1;
                    rd_last_next  = (b_reg == b_last);
                    rd_use_next   = (cfg.nbk != '0);
                    rd_user_next  = i_reg[UIDX_W-1:0];
                    if (b_reg == b_last)
                    begin
                        b_next = '0;
                        i_next = i_reg + NU_W'(1);
                    end
                    else
                    begin
                        b_next = b_reg + NB_W'(1);
                    end
                end
            end

            ST_PICK:
            begin
                if (!found_reg)
                begin
                    res_next       = '{kind: KIND_NONE, rec_book: '0, neighbour: '0, last: 1'b1};
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    b_next          = '0;
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // A qualifying book pushes out the one held back before it
                if (rd_valid_reg && liked && (count_reg < cfg.cap))
                begin
                    count_next = count_reg + CAP_W'(1);
                    if (pend_valid_reg)
                    begin
                        res_next = '{kind: KIND_REC, rec_book: pend_book_reg,
                                     neighbour: nb_reg, last: 1'b0};
                        res_valid_next = 1'b1;
                    end
                    pend_valid_next = 1'b1;
                    pend_book_next  = rd_book_reg;
                end
                if (emit_done && !rd_valid_reg)
                begin
                    if (pend_valid_reg)
                    begin
                        res_next = '{kind: KIND_REC, rec_book: pend_book_reg,
                                     neighbour: nb_reg, last: 1'b1};
                    end
                    else
                    begin
                        res_next = '{kind: KIND_NONE, rec_book: '0,
                                     neighbour: nb_reg, last: 1'b1};
                    end
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (!emit_done)
                begin
                    rd_valid_next = 1'b1;
                    rd_book_next  = b_reg[BIDX_W-1:0];
                    b_next        = b_reg + NB_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= rd_valid_next;
            res_valid_reg  <= res_valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        user_reg      <= user_next;
        i_reg         <= i_next;
        b_reg         <= b_next;
        acc_reg       <= acc_next;
        best_reg      <= best_next;
        nb_reg        <= nb_next;
        rd_last_reg   <= rd_last_next;
        rd_use_reg    <= rd_use_next;
        rd_user_reg   <= rd_user_next;
        rd_book_reg   <= rd_book_next;
        pend_book_reg <= pend_book_next;
        res_reg       <= res_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

`ifndef SYNTHESIS
    // The final result of a query leaves the engine idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.last |-> state_reg == ST_IDLE)
        else $error("query ended without returning to idle");

    // Recommendations never outnumber the cap
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> count_reg <= cfg.cap)
        else $error("recommendation count above cap");

    // A recommendation needs a neighbour
    a_rec_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.kind == KIND_REC |-> found_reg)
        else $error("recommendation without neighbour");
`endif

endmodule

### src/nearest_neighbour_recommender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbour_recommender
// User-by-book rating store with nearest neighbour book recommendation.
// ----------------------------------------------------------------------------
// Reset: busy stays high while the rating store is cleared.
// Write: result strobe in the cycle after the transfer; next command can follow.
// Query: busy while the engine runs; at most one store read pair per cycle.
// Results come one per cycle at most, are shown for one cycle only; no stall.
module nearest_neighbour_recommender (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nnr_pkg::cmd_t                  cmd,
    output nnr_pkg::res_t                  result,
    output logic                           result_valid,
    input  logic                           cfg_we,
    input  logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnr_pkg::CFG_W-1:0]      cfg_data
);
    import nnr_pkg::*;

    logic [NU_W-1:0]          num_users_reg;
    logic [NB_W-1:0]          num_books_reg;
    logic [CAP_W-1:0]         max_recs_reg;
    logic signed [RATE_W-1:0] like_thr_reg;
    logic                     clr_active_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic                     wr_valid_reg;
    logic [1:0]               wr_kind_reg;

    logic              accept;
    logic              rating_ok;
    logic              write_ok;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [RATE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] raddr_q, raddr_n;
    logic [RATE_W-1:0] rdata_q, rdata_n;
    qcfg_t             qcfg;
    qreq_t             qreq;
    logic              q_busy;
    res_t              q_res;
    logic              q_res_valid;

    assign accept = start && !busy;
    assign busy   = clr_active_reg || q_busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_users_reg <= '0;
            num_books_reg <= '0;
            max_recs_reg  <= CAP_W'(10);
            like_thr_reg  <= RATE_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_USERS:  num_users_reg <= cfg_data[NU_W-1:0];
                CFG_NUM_BOOKS:  num_books_reg <= cfg_data[NB_W-1:0];
                CFG_MAX_RECS:   max_recs_reg  <= cfg_data[CAP_W-1:0];
                CFG_LIKE_THRSH: like_thr_reg  <= cfg_data[RATE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Saturated settings
    assign qcfg.nu  = (num_users_reg > NU_W'(MAX_USERS)) ? NU_W'(MAX_USERS) : num_users_reg;
    assign qcfg.nbk = (num_books_reg > NB_W'(MAX_BOOKS)) ? NB_W'(MAX_BOOKS) : num_books_reg;
    assign qcfg.cap = (max_recs_reg > CAP_W'(RESULT_CAP)) ? CAP_W'(RESULT_CAP)
                                                          : max_recs_reg;
    assign qcfg.thr = like_thr_reg;

    // Write check; any 6-bit user index lies inside the store
    always_comb
    begin
        case (cmd.rating_value) inside
            -4'sd5, -4'sd3, 4'sd0, 4'sd1, 4'sd3, 4'sd5: rating_ok = 1'b1;
            default:                                     rating_ok = 1'b0;
        endcase
    end
    assign write_ok = rating_ok && ({1'b0, cmd.book_index} < qcfg.nbk);

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // RAM write port: clearing pass or accepted rating
    assign ram_we    = clr_active_reg || (accept && (cmd.action == ACT_WRITE) && write_ok);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : {cmd.user_index, cmd.book_index};
    assign ram_wdata = clr_active_reg ? '0 : cmd.rating_value;

    // Write result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
            wr_kind_reg  <= KIND_OK;
        end
        else
        begin
            wr_valid_reg <= accept && (cmd.action == ACT_WRITE);
            wr_kind_reg  <= write_ok ? KIND_OK : KIND_REJECT;
        end
    end

    assign qreq.go   = accept && (cmd.action == ACT_QUERY);
    assign qreq.user = cmd.user_index;

    nnr_ram #(
        .WIDTH (RATE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_q),
        .rdata_a (rdata_q),
        .raddr_b (raddr_n),
        .rdata_b (rdata_n)
    );

    nnr_query u_query (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (qreq),
        .cfg       (qcfg),
        .raddr_q   (raddr_q),
        .rdata_q   (rdata_q),
        .raddr_n   (raddr_n),
        .rdata_n   (rdata_n),
        .busy      (q_busy),
        .res       (q_res),
        .res_valid (q_res_valid)
    );

    // Result merge
    assign result_valid = wr_valid_reg || q_res_valid;
    assign result = wr_valid_reg
                  ? res_t'{kind: wr_kind_reg, rec_book: '0, neighbour: '0, last: 1'b1}
                  : q_res;

`ifndef SYNTHESIS
    // Write and query results never collide
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_valid_reg && q_res_valid))
        else $error("write and query results collide");

    // No command is taken during the clearing pass
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !accept)
        else $error("command taken while clearing");

    // A write result follows exactly one write transfer
    a_wr_follow: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.action == ACT_WRITE |=> wr_valid_reg)
        else $error("write result missing");
`endif

endmodule
